@@ sv/axis_antijitter_calibrate_assert.svh @@
// Assertion macros used by the checker file of the axis conditioner.
// Each macro expands to one labeled concurrent assertion reporting by $error.
`ifndef AXIS_ANTIJITTER_CALIBRATE_ASSERT_SVH
`define AXIS_ANTIJITTER_CALIBRATE_ASSERT_SVH

// same-cycle implication
`define AAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/aac_pkg.sv @@
// Shared types and constants of the axis anti-jitter and calibration block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aac_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int STRENGTH_BITS   = 8;
	localparam int APB_DATA_BITS   = 32;
	localparam int APB_ADDR_BITS   = 5;
	localparam int REG_IDX_BITS    = 3;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_JITTER_ENABLE    = 3'd0,
		REG_JITTER_MARGIN    = 3'd1,
		REG_JITTER_STRENGTH  = 3'd2,
		REG_CALIBRATE_ENABLE = 3'd3,
		REG_LEFT_LIMIT       = 3'd4,
		REG_CENTER_POSITION  = 3'd5,
		REG_RIGHT_LIMIT      = 3'd6,
		REG_NULL_HALF_WIDTH  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load_in;
		logic classify;
		logic multiply;
		logic div_init;
		logic div_step;
		logic load_out;
	} aac_cmd_t;

	typedef struct packed {
		logic use_div;
		logic div_last;
	} aac_sts_t;

endpackage

`default_nettype wire

@@ sv/axis_antijitter_calibrate.sv @@
// Channel      Handshake              Payload            Width
// raw          raw_valid/raw_ready    raw_sample         SAMPLE_BITS
// cal          cal_valid/cal_ready    calibrated_sample  SAMPLE_BITS
// cfg (APB)    psel/penable/pready    paddr, pwdata      5 / 32
//
// A sample that needs scaling goes through classify, multiply, divider load and the
// radix-4 serial divider from transfer to result. Samples that land in the null zone,
// clip, or bypass calibration skip the multiply and divide steps.
// One sample is in flight at a time; the next is taken while a result waits.
// Reset is asynchronous: held position and repeat count clear, registers return to defaults.
// Top level; depends on aac_pkg, aac_regs, aac_ctrl, aac_dp.
`timescale 1ns / 1ps
`default_nettype none

module axis_antijitter_calibrate
	import aac_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     raw_valid,
	output logic                          raw_ready,
	input  wire logic [SAMPLE_BITS-1:0]   raw_sample,
	output logic                          cal_valid,
	input  wire logic                     cal_ready,
	output logic      [SAMPLE_BITS-1:0]   calibrated_sample,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic      [APB_DATA_BITS-1:0] prdata,
	output logic                          pready
);

	logic                     jit_en;
	logic [SAMPLE_BITS-1:0]   jit_margin;
	logic [STRENGTH_BITS-1:0] jit_strength;
	logic                     cal_en;
	logic [SAMPLE_BITS-1:0]   left;
	logic [SAMPLE_BITS-1:0]   center;
	logic [SAMPLE_BITS-1:0]   right;
	logic [SAMPLE_BITS-1:0]   null_hw;
	aac_cmd_t                 cmd;
	aac_sts_t                 sts;

	aac_regs #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.jitter_enable    (jit_en),
		.jitter_margin    (jit_margin),
		.jitter_strength  (jit_strength),
		.calibrate_enable (cal_en),
		.left_limit       (left),
		.center_position  (center),
		.right_limit      (right),
		.null_half_width  (null_hw)
	);

	aac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_ready (raw_ready),
		.cal_valid (cal_valid),
		.cal_ready (cal_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	aac_dp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.raw_sample        (raw_sample),
		.jitter_enable     (jit_en),
		.jitter_margin     (jit_margin),
		.jitter_strength   (jit_strength),
		.calibrate_enable  (cal_en),
		.left_limit        (left),
		.center_position   (center),
		.right_limit       (right),
		.null_half_width   (null_hw),
		.calibrated_sample (calibrated_sample)
	);

endmodule

`default_nettype wire

@@ sv/aac_regs.sv @@
// APB configuration register file of the axis conditioner.
// Depends on aac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aac_regs
	import aac_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic      [APB_DATA_BITS-1:0] prdata,
	output logic                          pready,
	output logic                          jitter_enable,
	output logic      [SAMPLE_BITS-1:0]   jitter_margin,
	output logic      [STRENGTH_BITS-1:0] jitter_strength,
	output logic                          calibrate_enable,
	output logic      [SAMPLE_BITS-1:0]   left_limit,
	output logic      [SAMPLE_BITS-1:0]   center_position,
	output logic      [SAMPLE_BITS-1:0]   right_limit,
	output logic      [SAMPLE_BITS-1:0]   null_half_width
);

	localparam logic [SAMPLE_BITS-1:0] CENTER_RST = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
	localparam logic [SAMPLE_BITS-1:0] RIGHT_RST  = '1;

	logic                     jit_en_q;
	logic [SAMPLE_BITS-1:0]   jit_margin_q;
	logic [STRENGTH_BITS-1:0] jit_strength_q;
	logic                     cal_en_q;
	logic [SAMPLE_BITS-1:0]   left_q;
	logic [SAMPLE_BITS-1:0]   center_q;
	logic [SAMPLE_BITS-1:0]   right_q;
	logic [SAMPLE_BITS-1:0]   null_q;
	reg_idx_t                 idx;
	logic                     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jit_en_q       <= 1'b0;
			jit_margin_q   <= '0;
			jit_strength_q <= '0;
			cal_en_q       <= 1'b0;
			left_q         <= '0;
			center_q       <= CENTER_RST;
			right_q        <= RIGHT_RST;
			null_q         <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_JITTER_ENABLE:    jit_en_q       <= pwdata[0];
				REG_JITTER_MARGIN:    jit_margin_q   <= pwdata[SAMPLE_BITS-1:0];
				REG_JITTER_STRENGTH:  jit_strength_q <= pwdata[STRENGTH_BITS-1:0];
				REG_CALIBRATE_ENABLE: cal_en_q       <= pwdata[0];
				REG_LEFT_LIMIT:       left_q         <= pwdata[SAMPLE_BITS-1:0];
				REG_CENTER_POSITION:  center_q       <= pwdata[SAMPLE_BITS-1:0];
				REG_RIGHT_LIMIT:      right_q        <= pwdata[SAMPLE_BITS-1:0];
				REG_NULL_HALF_WIDTH:  null_q         <= pwdata[SAMPLE_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_JITTER_ENABLE:    prdata = APB_DATA_BITS'(jit_en_q);
			REG_JITTER_MARGIN:    prdata = APB_DATA_BITS'(jit_margin_q);
			REG_JITTER_STRENGTH:  prdata = APB_DATA_BITS'(jit_strength_q);
			REG_CALIBRATE_ENABLE: prdata = APB_DATA_BITS'(cal_en_q);
			REG_LEFT_LIMIT:       prdata = APB_DATA_BITS'(left_q);
			REG_CENTER_POSITION:  prdata = APB_DATA_BITS'(center_q);
			REG_RIGHT_LIMIT:      prdata = APB_DATA_BITS'(right_q);
			REG_NULL_HALF_WIDTH:  prdata = APB_DATA_BITS'(null_q);
		endcase
	end

	assign jitter_enable    = jit_en_q;
	assign jitter_margin    = jit_margin_q;
	assign jitter_strength  = jit_strength_q;
	assign calibrate_enable = cal_en_q;
	assign left_limit       = left_q;
	assign center_position  = center_q;
	assign right_limit      = right_q;
	assign null_half_width  = null_q;

endmodule

`default_nettype wire

@@ sv/aac_ctrl.sv @@
// Sequencing state machine of the axis conditioner: input transfer,
// classify, multiply, serial divide, result transfer. Depends on aac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aac_ctrl
	import aac_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     raw_valid,
	output logic          raw_ready,
	output logic          cal_valid,
	input  wire logic     cal_ready,
	output aac_cmd_t      cmd,
	input  wire aac_sts_t sts
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (cal_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		raw_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				raw_ready = 1'b1;
				if (raw_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = ST_CLASS;
				end
			end
			ST_CLASS: begin
				cmd.classify = 1'b1;
				state_nxt    = sts.use_div ? ST_MUL : ST_DONE;
			end
			ST_MUL: begin
				cmd.multiply = 1'b1;
				state_nxt    = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.div_init = 1'b1;
				state_nxt    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || cal_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign cal_valid = out_valid_q;

endmodule

`default_nettype wire

@@ sv/aac_dp.sv @@
// Datapath of the axis conditioner: anti-jitter hold, zone classification,
// multiplier, radix-4 restoring divider and output register. Depends on aac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aac_dp
	import aac_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire aac_cmd_t                 cmd,
	output aac_sts_t                      sts,
	input  wire logic [SAMPLE_BITS-1:0]   raw_sample,
	input  wire logic                     jitter_enable,
	input  wire logic [SAMPLE_BITS-1:0]   jitter_margin,
	input  wire logic [STRENGTH_BITS-1:0] jitter_strength,
	input  wire logic                     calibrate_enable,
	input  wire logic [SAMPLE_BITS-1:0]   left_limit,
	input  wire logic [SAMPLE_BITS-1:0]   center_position,
	input  wire logic [SAMPLE_BITS-1:0]   right_limit,
	input  wire logic [SAMPLE_BITS-1:0]   null_half_width,
	output logic      [SAMPLE_BITS-1:0]   calibrated_sample
);

	localparam int W         = SAMPLE_BITS;
	localparam int DIV_BITS  = 2 * W + 1;
	localparam int DIV_STEPS = (DIV_BITS + 1) / 2;
	localparam int NW        = 2 * DIV_STEPS;
	localparam int CNT_BITS  = $clog2(DIV_STEPS);

	// anti-jitter state
	logic [W-1:0]             held_q;
	logic [STRENGTH_BITS-1:0] rpt_q;
	logic [W-1:0]             filt_q;

	// classification results
	logic         use_div_q;
	logic [W-1:0] val_q;
	logic [W-1:0] p_q;
	logic [W-1:0] m_q;
	logic [W-1:0] d_q;
	logic [W-1:0] off_q;

	// multiplier and divider
	logic [2*W-1:0]      prod_q;
	logic [NW-1:0]       num_q;
	logic [W-1:0]        rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [W-1:0]        out_q;

	// anti-jitter combinational
	logic [W-1:0] hs_diff;
	logic         in_window;
	logic         hold;

	// classify combinational
	logic [W-1:0] fc_diff;
	logic [W-1:0] w1;
	logic [W-1:0] w2;
	logic         cls_div;
	logic [W-1:0] cls_val;
	logic [W-1:0] cls_p;
	logic [W-1:0] cls_m;
	logic [W-1:0] cls_d;
	logic [W-1:0] cls_off;

	// divide step
	logic [W:0]   t1;
	logic [W:0]   r1;
	logic [W:0]   t2;
	logic [W:0]   r2;
	logic         ge1;
	logic         ge2;

	assign hs_diff   = (raw_sample >= held_q) ? raw_sample - held_q : held_q - raw_sample;
	assign in_window = (raw_sample != held_q) && (hs_diff <= jitter_margin);
	assign hold      = jitter_enable && in_window && (rpt_q < jitter_strength);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			rpt_q  <= '0;
		end else if (cmd.load_in && jitter_enable) begin
			if (hold) begin
				rpt_q <= rpt_q + STRENGTH_BITS'(1);
			end else begin
				rpt_q  <= '0;
				held_q <= raw_sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			filt_q <= hold ? held_q : raw_sample;
		end
	end

	assign fc_diff = (filt_q >= center_position) ? filt_q - center_position
		: center_position - filt_q;
	assign w1 = center_position - null_half_width - left_limit;
	assign w2 = right_limit - center_position - null_half_width;

	always_comb begin
		cls_div = 1'b0;
		cls_val = center_position;
		cls_p   = filt_q - left_limit;
		cls_m   = center_position;
		cls_d   = w1;
		cls_off = '0;
		priority if (!calibrate_enable) begin
			cls_val = filt_q;
		end else if (fc_diff <= null_half_width) begin
			cls_val = center_position;
		end else if (filt_q < left_limit) begin
			cls_val = '0;
		end else if (filt_q >= right_limit) begin
			cls_val = right_limit;
		end else if (filt_q < center_position) begin
			cls_div = (w1 != '0);
		end else begin
			cls_div = (w2 != '0);
			cls_p   = filt_q - center_position - null_half_width - W'(1);
			cls_m   = right_limit - center_position;
			cls_d   = w2;
			cls_off = center_position + W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			use_div_q <= cls_div;
			val_q     <= cls_val;
			p_q       <= cls_p;
			m_q       <= cls_m;
			d_q       <= cls_d;
			off_q     <= cls_off;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.multiply) begin
			prod_q <= p_q * m_q;
		end
	end

	// two restoring steps per cycle
	always_comb begin
		t1  = {rem_q, num_q[NW-1]};
		ge1 = t1 >= {1'b0, d_q};
		r1  = ge1 ? t1 - {1'b0, d_q} : t1;
		t2  = {r1[W-1:0], num_q[NW-2]};
		ge2 = t2 >= {1'b0, d_q};
		r2  = ge2 ? t2 - {1'b0, d_q} : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= CNT_BITS'(DIV_STEPS - 1);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			num_q <= NW'(prod_q) + NW'(d_q >> 1);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NW-3:0], ge1, ge2};
			rem_q <= r2[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= use_div_q ? num_q[W-1:0] + off_q : val_q;
		end
	end

	assign sts.use_div    = cls_div;
	assign sts.div_last   = (cnt_q == '0);
	assign calibrated_sample = out_q;

endmodule

`default_nettype wire

@@ sv/aac_checker.sv @@
// Port-level checker for axis_antijitter_calibrate, bound to the top level.
// Depends on aac_pkg and axis_antijitter_calibrate_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "axis_antijitter_calibrate_assert.svh"

module aac_checker
	import aac_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     raw_valid,
	input wire logic                     raw_ready,
	input wire logic                     cal_valid,
	input wire logic                     cal_ready,
	input wire logic [SAMPLE_BITS-1:0]   calibrated_sample,
	input wire logic                     psel,
	input wire logic                     penable,
	input wire logic                     pready
);

	logic raw_xfer;

	assign raw_xfer = raw_valid && raw_ready;

	`AAC_ASSERT_NEXT(a_cal_hold, clk, arst_n, cal_valid && !cal_ready, cal_valid && $stable(calibrated_sample), "stalled result changed")
	`AAC_ASSERT_NEXT(a_one_in_flight, clk, arst_n, raw_xfer, !raw_ready, "second sample taken while one is in flight")
	`AAC_ASSERT_NEXT(a_no_instant_result, clk, arst_n, raw_xfer, !$rose(cal_valid), "result appeared one cycle after input transfer")
	`AAC_ASSERT_NOW(a_pready, clk, arst_n, psel && penable, pready, "APB access stalled")

endmodule

bind axis_antijitter_calibrate aac_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_aac_checker (.*);

`default_nettype wire
